### hdl/fwsc_pkg.sv
// Package with the shared types and codes of the FIFO with search and compaction.
`timescale 1ns / 1ps
`default_nettype none

package fwsc_pkg;

    typedef enum logic [2:0] {
        OP_PUSH         = 3'd0,
        OP_POP          = 3'd1,
        OP_REPLACE_ALL  = 3'd2,
        OP_REMOVE_FIRST = 3'd3,
        OP_REMOVE_DUPS  = 3'd4,
        OP_REMOVE_EVEN  = 3'd5,
        OP_CLEAR        = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_EV,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DUP_RD,
        S_DUP_EV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic pop_take;
        logic rd_scan;
        logic scan_eval;
        logic dup_start;
        logic rd_dup;
        logic dup_drop;
        logic dup_keep;
        logic dup_next;
        logic scan_end;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic scan_done;
        logic n_zero;
        logic dup_match;
        logic dup_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### hdl/fwsc_ctrl.sv
// Controller state machine that sequences each queue operation.
`timescale 1ns / 1ps
`default_nettype none

module fwsc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire fwsc_pkg::t_stat i_stat,
    output fwsc_pkg::t_cmd      o_cmd
);

    fwsc_pkg::t_state r_state;
    fwsc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fwsc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = fwsc_pkg::S_EXEC;
                end
            end
            fwsc_pkg::S_EXEC: begin
                case (i_stat.op)
                    fwsc_pkg::OP_POP: begin
                        n_state = i_stat.empty ? fwsc_pkg::S_FIN : fwsc_pkg::S_POP_EV;
                    end
                    fwsc_pkg::OP_REPLACE_ALL, fwsc_pkg::OP_REMOVE_FIRST,
                    fwsc_pkg::OP_REMOVE_DUPS, fwsc_pkg::OP_REMOVE_EVEN: begin
                        n_state = fwsc_pkg::S_SCAN_RD;
                    end
                    default: begin
                        n_state = fwsc_pkg::S_FIN;
                    end
                endcase
            end
            fwsc_pkg::S_POP_EV: begin
                n_state = fwsc_pkg::S_FIN;
            end
            fwsc_pkg::S_SCAN_RD: begin
                n_state = i_stat.scan_done ? fwsc_pkg::S_FIN : fwsc_pkg::S_SCAN_EV;
            end
            fwsc_pkg::S_SCAN_EV: begin
                if (i_stat.op == fwsc_pkg::OP_REMOVE_DUPS && !i_stat.n_zero) begin
                    n_state = fwsc_pkg::S_DUP_RD;
                end else begin
                    n_state = fwsc_pkg::S_SCAN_RD;
                end
            end
            fwsc_pkg::S_DUP_RD: begin
                n_state = fwsc_pkg::S_DUP_EV;
            end
            fwsc_pkg::S_DUP_EV: begin
                if (i_stat.dup_match || i_stat.dup_last) begin
                    n_state = fwsc_pkg::S_SCAN_RD;
                end else begin
                    n_state = fwsc_pkg::S_DUP_RD;
                end
            end
            fwsc_pkg::S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = fwsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fwsc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fwsc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            fwsc_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            fwsc_pkg::S_POP_EV: begin
                o_cmd.pop_take = 1'b1;
            end
            fwsc_pkg::S_SCAN_RD: begin
                o_cmd.scan_end = i_stat.scan_done;
                o_cmd.rd_scan  = !i_stat.scan_done;
            end
            fwsc_pkg::S_SCAN_EV: begin
                if (i_stat.op == fwsc_pkg::OP_REMOVE_DUPS) begin
                    o_cmd.dup_start = 1'b1;
                end else begin
                    o_cmd.scan_eval = 1'b1;
                end
            end
            fwsc_pkg::S_DUP_RD: begin
                o_cmd.rd_dup = 1'b1;
            end
            fwsc_pkg::S_DUP_EV: begin
                o_cmd.dup_drop = i_stat.dup_match;
                o_cmd.dup_keep = !i_stat.dup_match && i_stat.dup_last;
                o_cmd.dup_next = !i_stat.dup_match && !i_stat.dup_last;
            end
            fwsc_pkg::S_FIN: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/fwsc_dp.sv
// Datapath with the ring memory, pointers, scan counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module fwsc_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fwsc_pkg::t_cmd     i_cmd,
    output fwsc_pkg::t_stat         o_stat,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_value,
    input  wire logic signed [31:0] i_new_value,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic signed [31:0]      o_read_value,
    output logic [1:0]              o_status,
    output logic [4:0]              o_entry_total
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic [31:0]       r_mem [DEPTH];
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_n;
    logic [CW-1:0]     r_j;
    logic              r_found;
    logic              r_out_valid;
    fwsc_pkg::t_op     r_op;
    fwsc_pkg::t_status r_status;
    logic [31:0]       r_value;
    logic [31:0]       r_new_value;
    logic [31:0]       r_cur;
    logic [31:0]       r_rd_data;
    logic [31:0]       r_rd_val;
    logic [31:0]       r_out_value;
    logic [1:0]        r_out_status;
    logic [4:0]        r_out_total;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [31:0]       wr_data;
    logic              val_match;
    logic              scan_keep;
    logic              scan_hit;
    logic              full;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos[AW-1:0]};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign full      = (r_count == DEPTH_C);
    assign val_match = (r_rd_data == r_value);

    always_comb begin
        scan_keep = 1'b0;
        scan_hit  = 1'b0;
        case (r_op)
            fwsc_pkg::OP_REPLACE_ALL: begin
                scan_hit = val_match;
            end
            fwsc_pkg::OP_REMOVE_FIRST: begin
                scan_hit  = !r_found && val_match;
                scan_keep = !scan_hit;
            end
            fwsc_pkg::OP_REMOVE_EVEN: begin
                scan_keep = r_rd_data[0];
            end
            default: begin
                scan_keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_head;
        if (i_cmd.exec && r_op == fwsc_pkg::OP_POP) begin
            rd_en   = 1'b1;
            rd_addr = r_head;
        end else if (i_cmd.rd_scan) begin
            rd_en   = 1'b1;
            rd_addr = slot_of(r_head, r_i);
        end else if (i_cmd.rd_dup) begin
            rd_en   = 1'b1;
            rd_addr = slot_of(r_head, r_j);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_of(r_head, r_n);
        wr_data = r_rd_data;
        if (i_cmd.exec && r_op == fwsc_pkg::OP_PUSH) begin
            wr_en   = !full;
            wr_addr = slot_of(r_head, r_count);
            wr_data = r_value;
        end else if (i_cmd.scan_eval && r_op == fwsc_pkg::OP_REPLACE_ALL) begin
            wr_en   = scan_hit;
            wr_addr = slot_of(r_head, r_i);
            wr_data = r_new_value;
        end else if (i_cmd.scan_eval) begin
            wr_en   = scan_keep;
        end else if (i_cmd.dup_start) begin
            wr_en   = (r_n == '0);
        end else if (i_cmd.dup_keep) begin
            wr_en   = 1'b1;
            wr_data = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_i         <= '0;
            r_n         <= '0;
            r_j         <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    fwsc_pkg::OP_PUSH: begin
                        if (!full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    fwsc_pkg::OP_CLEAR: begin
                        r_head  <= '0;
                        r_count <= '0;
                    end
                    fwsc_pkg::OP_REPLACE_ALL, fwsc_pkg::OP_REMOVE_FIRST,
                    fwsc_pkg::OP_REMOVE_DUPS, fwsc_pkg::OP_REMOVE_EVEN: begin
                        r_i <= '0;
                        r_n <= '0;
                    end
                    default: begin
                        r_i <= r_i;
                    end
                endcase
            end
            if (i_cmd.pop_take) begin
                r_head  <= (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.scan_eval) begin
                r_i <= r_i + CW'(1);
                if (scan_keep) begin
                    r_n <= r_n + CW'(1);
                end
                if (scan_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.dup_start) begin
                r_j <= '0;
                if (r_n == '0) begin
                    r_n <= r_n + CW'(1);
                    r_i <= r_i + CW'(1);
                end
            end
            if (i_cmd.dup_drop) begin
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.dup_keep) begin
                r_n <= r_n + CW'(1);
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.dup_next) begin
                r_j <= r_j + CW'(1);
            end
            if (i_cmd.scan_end && r_op != fwsc_pkg::OP_REPLACE_ALL) begin
                r_count <= r_n;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= fwsc_pkg::t_op'(i_operation);
            r_value     <= i_value;
            r_new_value <= i_new_value;
            r_status    <= fwsc_pkg::ST_OK;
            r_rd_val    <= '0;
        end
        if (i_cmd.exec) begin
            if (r_op == fwsc_pkg::OP_PUSH && full) begin
                r_status <= fwsc_pkg::ST_FULL;
            end
            if (r_op == fwsc_pkg::OP_POP && r_count == '0) begin
                r_rd_val <= '1;
                r_status <= fwsc_pkg::ST_EMPTY;
            end
        end
        if (i_cmd.pop_take) begin
            r_rd_val <= r_rd_data;
        end
        if (i_cmd.scan_end && !r_found &&
            (r_op == fwsc_pkg::OP_REPLACE_ALL || r_op == fwsc_pkg::OP_REMOVE_FIRST)) begin
            r_status <= fwsc_pkg::ST_NOT_FOUND;
        end
        if (i_cmd.dup_start) begin
            r_cur <= r_rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_value  <= r_rd_val;
            r_out_status <= r_status;
            r_out_total  <= 5'(r_count);
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.scan_done = (r_i == r_count);
    assign o_stat.n_zero    = (r_n == '0);
    assign o_stat.dup_match = (r_rd_data == r_cur);
    assign o_stat.dup_last  = ((r_j + CW'(1)) == r_n);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_status      = r_out_status;
    assign o_entry_total = r_out_total;

endmodule

`default_nettype wire

### hdl/fifo_with_search_and_compaction.sv
// Top level of the bounded FIFO with search, replace and compaction.
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_ready   i_operation, i_value, i_new_value
//  output    out        o_out_valid / i_out_ready o_read_value, o_status, o_entry_total
//
// One operation is in flight at a time; a new beat is taken while the last result waits.
// Push, clear and unused codes end after exec; a pop adds a take step unless empty.
// Replace all, remove first and remove even take one memory read for each entry.
// Remove duplicates compares each entry with the kept ones over the single read port.
// Reset is synchronous and needs no clearing pass; a held result stalls only the finish step.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_search_and_compaction #(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_value,
    input  wire logic signed [31:0] i_new_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_read_value,
    output logic [1:0]              o_status,
    output logic [4:0]              o_entry_total
);

    fwsc_pkg::t_cmd  cmd;
    fwsc_pkg::t_stat stat;

    fwsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fwsc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_new_value   (i_new_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_total (o_entry_total)
    );

endmodule

`default_nettype wire
